// ===== rtl/hdep_pkg.sv =====
// Shared types, constants and tables for the HTTP date parser.
package hdep_pkg;

  // Field widths of the input and result words.
  localparam int unsigned CharW  = 8;
  localparam int unsigned EpochW = 39;

  // Numeric limits of the parsed fields.
  localparam int unsigned FieldW = 16;
  localparam int unsigned YearW  = 14;
  localparam logic [FieldW-1:0] FieldMax = 16'd65535;
  localparam logic [YearW-1:0]  YearMax  = 14'd9999;

  // Target of a digit accumulation.
  typedef enum logic [2:0] {
    ACC_DAY,
    ACC_YEAR,
    ACC_HOUR,
    ACC_MIN,
    ACC_SEC
  } acc_sel_e;

  // Step of the epoch conversion sequence.
  typedef enum logic [2:0] {
    CV_NONE,
    CV_ADJ,
    CV_Q100,
    CV_DSUM,
    CV_DAYS,
    CV_SECS,
    CV_HOUR,
    CV_MIN
  } conv_step_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       acc_en;
    acc_sel_e   acc_sel;
    logic       mon_shift;
    logic       mon_clear;
    logic       mon_match;
    logic       yat;
    conv_step_e step;
    logic       out_load;
  } hdep_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } hdep_sts_t;

  // Three lower-case letters of a month name to its number, zero when unknown.
  function automatic logic [3:0] hdep_month_lookup(logic [23:0] key);
    logic [3:0] m;
    case (key)
      24'h6a616e: m = 4'd1;
      24'h666562: m = 4'd2;
      24'h6d6172: m = 4'd3;
      24'h617072: m = 4'd4;
      24'h6d6179: m = 4'd5;
      24'h6a756e: m = 4'd6;
      24'h6a756c: m = 4'd7;
      24'h617567: m = 4'd8;
      24'h736570: m = 4'd9;
      24'h6f6374: m = 4'd10;
      24'h6e6f76: m = 4'd11;
      24'h646563: m = 4'd12;
      default:    m = 4'd0;
    endcase
    return m;
  endfunction

  // Days before the month in a March-based year: (153*m - 457) / 5 for m = 3..14.
  function automatic logic [8:0] hdep_month_offset(logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      4'd13:   d = 9'd306;
      4'd14:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/hdep_if.sv =====
// Stream interfaces for the character input and the epoch result.
interface hdep_char_if;
  logic                         valid;
  logic                         ready;
  logic [hdep_pkg::CharW-1:0]   char_byte;
  logic                         is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

interface hdep_epoch_if;
  logic                                valid;
  logic                                ready;
  logic signed [hdep_pkg::EpochW-1:0]  epoch_seconds;
  logic                                month_found;

  modport source (output valid, output epoch_seconds, output month_found, input ready);
  modport sink   (input valid, input epoch_seconds, input month_found, output ready);
endinterface

// ===== rtl/hdep_ctrl.sv =====
// Controller: character scanner state machine and conversion sequencer.
module hdep_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [hdep_pkg::CharW-1:0] char_byte_i,
  input  logic                       is_last_i,
  output logic                       in_ready_o,
  input  hdep_pkg::hdep_sts_t        sts_i,
  output hdep_pkg::hdep_cmd_t        cmd_o
);

  // Scan phases.
  localparam logic [4:0] PH_LEAD    = 5'd0;
  localparam logic [4:0] PH_WEEK    = 5'd1;
  localparam logic [4:0] PH_SP2     = 5'd2;
  localparam logic [4:0] PH_DAYNUM  = 5'd3;
  localparam logic [4:0] PH_DAYSKIP = 5'd4;
  localparam logic [4:0] PH_MON0    = 5'd5;
  localparam logic [4:0] PH_MON1    = 5'd6;
  localparam logic [4:0] PH_MON2    = 5'd7;
  localparam logic [4:0] PH_MONSKIP = 5'd8;
  localparam logic [4:0] PH_YDNUM   = 5'd9;
  localparam logic [4:0] PH_YDSKIP  = 5'd10;
  localparam logic [4:0] PH_SPH     = 5'd11;
  localparam logic [4:0] PH_HNUM    = 5'd12;
  localparam logic [4:0] PH_HSKIP   = 5'd13;
  localparam logic [4:0] PH_MNUM    = 5'd14;
  localparam logic [4:0] PH_MSKIP   = 5'd15;
  localparam logic [4:0] PH_SNUM    = 5'd16;
  localparam logic [4:0] PH_TSKIP   = 5'd17;
  localparam logic [4:0] PH_SPY     = 5'd18;
  localparam logic [4:0] PH_YNUM    = 5'd19;
  localparam logic [4:0] PH_IDLE    = 5'd20;

  // Top-level states.
  localparam logic [3:0] ST_PARSE = 4'd0;
  localparam logic [3:0] ST_ADJ   = 4'd1;
  localparam logic [3:0] ST_Q100  = 4'd2;
  localparam logic [3:0] ST_DSUM  = 4'd3;
  localparam logic [3:0] ST_DAYS  = 4'd4;
  localparam logic [3:0] ST_SECS  = 4'd5;
  localparam logic [3:0] ST_HOUR  = 4'd6;
  localparam logic [3:0] ST_MIN   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  // Character codes.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  logic [3:0] state_q, state_d;
  logic [4:0] phase_q, phase_d;
  logic       yat_q, yat_d;
  logic       accept;
  logic       is_ws, is_dig, is_delim, is_colon, is_comma;

  // Character classes.
  assign is_ws    = (char_byte_i == ChSpace) || (char_byte_i >= ChTab && char_byte_i <= ChCr);
  assign is_dig   = (char_byte_i >= ChZero) && (char_byte_i <= ChNine);
  assign is_delim = (char_byte_i == ChDash) || is_ws;
  assign is_colon = (char_byte_i == ChColon);
  assign is_comma = (char_byte_i == ChComma);

  assign in_ready_o = (state_q == ST_PARSE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and datapath commands. Each scan phase resolves every phase
  // change that a single character causes.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    yat_d   = yat_q;
    cmd_o   = '0;
    cmd_o.acc_sel = hdep_pkg::ACC_DAY;
    cmd_o.step    = hdep_pkg::CV_NONE;
    cmd_o.yat     = yat_q;
    unique case (state_q)
      ST_PARSE: begin
        if (accept) begin
          unique case (phase_q) inside
            PH_LEAD: begin
              if (!is_ws) begin
                phase_d = is_comma ? PH_SP2 : PH_WEEK;
              end
            end
            PH_WEEK: begin
              if (is_comma || is_ws) begin
                phase_d = PH_SP2;
              end
            end
            PH_SP2: begin
              if (is_dig) begin
                yat_d         = 1'b0;
                cmd_o.acc_en  = 1'b1;
                cmd_o.acc_sel = hdep_pkg::ACC_DAY;
                phase_d       = PH_DAYNUM;
              end else if (is_delim && !is_ws) begin
                cmd_o.mon_clear = 1'b1;
                phase_d         = PH_YDNUM;
              end else if (!is_ws) begin
                cmd_o.mon_shift = 1'b1;
                phase_d         = PH_MON1;
              end
            end
            PH_DAYNUM: begin
              if (is_dig) begin
                cmd_o.acc_en  = 1'b1;
                cmd_o.acc_sel = hdep_pkg::ACC_DAY;
              end else begin
                phase_d = is_delim ? PH_MON0 : PH_DAYSKIP;
              end
            end
            PH_DAYSKIP: begin
              if (is_delim) begin
                phase_d = PH_MON0;
              end
            end
            PH_MON0, PH_MON1: begin
              if (is_delim) begin
                cmd_o.mon_clear = 1'b1;
                phase_d         = PH_YDNUM;
              end else begin
                cmd_o.mon_shift = 1'b1;
                phase_d         = phase_q + 5'd1;
              end
            end
            PH_MON2: begin
              cmd_o.mon_match = 1'b1;
              phase_d         = is_delim ? PH_YDNUM : PH_MONSKIP;
            end
            PH_MONSKIP: begin
              if (is_delim) begin
                phase_d = PH_YDNUM;
              end
            end
            PH_YDNUM: begin
              if (is_dig) begin
                cmd_o.acc_en  = 1'b1;
                cmd_o.acc_sel = yat_q ? hdep_pkg::ACC_DAY : hdep_pkg::ACC_YEAR;
              end else begin
                phase_d = is_ws ? PH_SPH : PH_YDSKIP;
              end
            end
            PH_YDSKIP: begin
              if (is_ws) begin
                phase_d = PH_SPH;
              end
            end
            PH_SPH: begin
              if (is_dig) begin
                cmd_o.acc_en  = 1'b1;
                cmd_o.acc_sel = hdep_pkg::ACC_HOUR;
                phase_d       = PH_HNUM;
              end else if (!is_ws) begin
                phase_d = is_colon ? PH_MNUM : PH_HSKIP;
              end
            end
            PH_HNUM: begin
              if (is_dig) begin
                cmd_o.acc_en  = 1'b1;
                cmd_o.acc_sel = hdep_pkg::ACC_HOUR;
              end else begin
                phase_d = is_colon ? PH_MNUM : PH_HSKIP;
              end
            end
            PH_HSKIP: begin
              if (is_colon) begin
                phase_d = PH_MNUM;
              end
            end
            PH_MNUM: begin
              if (is_dig) begin
                cmd_o.acc_en  = 1'b1;
                cmd_o.acc_sel = hdep_pkg::ACC_MIN;
              end else begin
                phase_d = is_colon ? PH_SNUM : PH_MSKIP;
              end
            end
            PH_MSKIP: begin
              if (is_colon) begin
                phase_d = PH_SNUM;
              end
            end
            PH_SNUM: begin
              if (is_dig) begin
                cmd_o.acc_en  = 1'b1;
                cmd_o.acc_sel = hdep_pkg::ACC_SEC;
              end else if (yat_q) begin
                phase_d = is_ws ? PH_SPY : PH_TSKIP;
              end else begin
                phase_d = PH_IDLE;
              end
            end
            PH_TSKIP: begin
              if (is_ws) begin
                phase_d = PH_SPY;
              end
            end
            PH_SPY: begin
              if (is_dig) begin
                cmd_o.acc_en  = 1'b1;
                cmd_o.acc_sel = hdep_pkg::ACC_YEAR;
                phase_d       = PH_YNUM;
              end else if (!is_ws) begin
                phase_d = PH_IDLE;
              end
            end
            PH_YNUM: begin
              if (is_dig) begin
                cmd_o.acc_en  = 1'b1;
                cmd_o.acc_sel = hdep_pkg::ACC_YEAR;
              end else begin
                phase_d = PH_IDLE;
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
          if (is_last_i) begin
            state_d = ST_ADJ;
          end
        end
      end
      ST_ADJ: begin
        cmd_o.step = hdep_pkg::CV_ADJ;
        state_d    = ST_Q100;
      end
      ST_Q100: begin
        cmd_o.step = hdep_pkg::CV_Q100;
        state_d    = ST_DSUM;
      end
      ST_DSUM: begin
        cmd_o.step = hdep_pkg::CV_DSUM;
        state_d    = ST_DAYS;
      end
      ST_DAYS: begin
        cmd_o.step = hdep_pkg::CV_DAYS;
        state_d    = ST_SECS;
      end
      ST_SECS: begin
        cmd_o.step = hdep_pkg::CV_SECS;
        state_d    = ST_HOUR;
      end
      ST_HOUR: begin
        cmd_o.step = hdep_pkg::CV_HOUR;
        state_d    = ST_MIN;
      end
      ST_MIN: begin
        cmd_o.step = hdep_pkg::CV_MIN;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free, then rearm.
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_PARSE;
          phase_d        = PH_LEAD;
          yat_d          = 1'b1;
        end
      end
      default: begin
        state_d = ST_PARSE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PARSE;
      phase_q <= PH_LEAD;
      yat_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      yat_q   <= yat_d;
    end
  end

endmodule

// ===== rtl/hdep_datapath.sv =====
// Datapath: field accumulators, month matcher, epoch arithmetic and result register.
module hdep_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [hdep_pkg::CharW-1:0]        char_byte_i,
  input  hdep_pkg::hdep_cmd_t               cmd_i,
  output hdep_pkg::hdep_sts_t               sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [hdep_pkg::EpochW-1:0] epoch_seconds_o,
  output logic                              month_found_o
);

  localparam int unsigned AccW = 42;

  logic [hdep_pkg::FieldW-1:0] day_q, hour_q, min_q, sec_q;
  logic [hdep_pkg::YearW-1:0]  year_q;
  logic [3:0]                  mon_q;
  logic [15:0]                 letters_q;
  logic [hdep_pkg::YearW-1:0]  y_adj_q, y_adj_d;
  logic [3:0]                  m_adj_q, m_adj_d;
  logic [6:0]                  q100_q, q100_d;
  logic signed [AccW-1:0]      acc_q, acc_d;
  logic                        out_valid_q;
  logic signed [hdep_pkg::EpochW-1:0] epoch_q;
  logic                        found_q;

  logic [7:0]                  folded;
  logic [3:0]                  digit;
  logic [hdep_pkg::FieldW-1:0] acc_cur, acc_lim, acc_new;
  logic [19:0]                 acc_sum;
  logic signed [24:0]          mul_a;
  logic signed [17:0]          mul_b;
  logic signed [42:0]          prod;
  logic [hdep_pkg::YearW-1:0]  y_tmp;

  // Lower-case fold of letters and digit value.
  assign folded = (char_byte_i >= 8'h41 && char_byte_i <= 8'h5a) ?
                  (char_byte_i | 8'h20) : char_byte_i;
  assign digit  = char_byte_i[3:0];

  // Decimal accumulator shared by all numeric fields: v*10 + digit, saturating.
  always_comb begin
    case (cmd_i.acc_sel)
      hdep_pkg::ACC_YEAR: acc_cur = {2'b00, year_q};
      hdep_pkg::ACC_HOUR: acc_cur = hour_q;
      hdep_pkg::ACC_MIN:  acc_cur = min_q;
      hdep_pkg::ACC_SEC:  acc_cur = sec_q;
      default:            acc_cur = day_q;
    endcase
    acc_lim = (cmd_i.acc_sel == hdep_pkg::ACC_YEAR) ? {2'b00, hdep_pkg::YearMax} :
                                                      hdep_pkg::FieldMax;
    acc_sum = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0} + {16'd0, digit};
    acc_new = (acc_sum > {4'd0, acc_lim}) ? acc_lim : acc_sum[15:0];
  end

  // Parsed fields; cleared when the result is handed over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q     <= '0;
      year_q    <= '0;
      hour_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      mon_q     <= '0;
      letters_q <= '0;
    end else if (cmd_i.out_load) begin
      day_q     <= '0;
      year_q    <= '0;
      hour_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      mon_q     <= '0;
      letters_q <= '0;
    end else begin
      if (cmd_i.acc_en) begin
        case (cmd_i.acc_sel)
          hdep_pkg::ACC_YEAR: year_q <= acc_new[hdep_pkg::YearW-1:0];
          hdep_pkg::ACC_HOUR: hour_q <= acc_new;
          hdep_pkg::ACC_MIN:  min_q  <= acc_new;
          hdep_pkg::ACC_SEC:  sec_q  <= acc_new;
          default:            day_q  <= acc_new;
        endcase
      end
      if (cmd_i.mon_shift) begin
        letters_q <= {letters_q[7:0], folded};
      end
      if (cmd_i.mon_clear) begin
        mon_q <= '0;
      end else if (cmd_i.mon_match) begin
        mon_q <= hdep_pkg::hdep_month_lookup({letters_q, folded});
      end
    end
  end

  // One shared multiplier; the sequencer steps operands through it.
  assign prod = mul_a * mul_b;

  always_comb begin
    y_adj_d = y_adj_q;
    m_adj_d = m_adj_q;
    q100_d  = q100_q;
    acc_d   = acc_q;
    mul_a   = '0;
    mul_b   = '0;
    y_tmp   = year_q;
    case (cmd_i.step)
      hdep_pkg::CV_ADJ: begin
        // Century fix for two-digit years, then shift to a March-based year.
        if (year_q < 14'd100) begin
          y_tmp = year_q + (cmd_i.yat ? 14'd1900 : 14'd2000);
        end
        if (mon_q < 4'd3) begin
          m_adj_d = mon_q + 4'd12;
          y_adj_d = y_tmp - 14'd1;
        end else begin
          m_adj_d = mon_q;
          y_adj_d = y_tmp;
        end
      end
      hdep_pkg::CV_Q100: begin
        // y / 100 as a reciprocal multiply, exact for the year range.
        mul_a  = $signed({11'd0, y_adj_q});
        mul_b  = 18'sd5243;
        q100_d = prod[25:19];
      end
      hdep_pkg::CV_DSUM: begin
        acc_d = $signed({26'd0, day_q})
              + $signed({33'd0, hdep_pkg::hdep_month_offset(m_adj_q)})
              + $signed({30'd0, y_adj_q[hdep_pkg::YearW-1:2]})
              - $signed({35'd0, q100_q})
              + $signed({37'd0, q100_q[6:2]})
              - 42'sd719469;
      end
      hdep_pkg::CV_DAYS: begin
        mul_a = $signed({11'd0, y_adj_q});
        mul_b = 18'sd365;
        acc_d = acc_q + $signed(prod[AccW-1:0]);
      end
      hdep_pkg::CV_SECS: begin
        mul_a = acc_q[24:0];
        mul_b = 18'sd86400;
        acc_d = $signed(prod[AccW-1:0]) + $signed({26'd0, sec_q});
      end
      hdep_pkg::CV_HOUR: begin
        mul_a = $signed({9'd0, hour_q});
        mul_b = 18'sd3600;
        acc_d = acc_q + $signed(prod[AccW-1:0]);
      end
      hdep_pkg::CV_MIN: begin
        mul_a = $signed({9'd0, min_q});
        mul_b = 18'sd60;
        acc_d = acc_q + $signed(prod[AccW-1:0]);
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  // Conversion working registers.
  always_ff @(posedge clk_i) begin
    y_adj_q <= y_adj_d;
    m_adj_q <= m_adj_d;
    q100_q  <= q100_d;
    acc_q   <= acc_d;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      epoch_q <= acc_q[hdep_pkg::EpochW-1:0];
      found_q <= (mon_q != 4'd0);
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign epoch_seconds_o = epoch_q;
  assign month_found_o   = found_q;

endmodule

// ===== rtl/http_date_to_epoch_parser_core.sv =====
// After the last character the states ADJ, Q100, DSUM, DAYS, SECS, HOUR and MIN step
// through the epoch arithmetic on one shared multiplier; DONE loads the result register
// once it is free. Throughput: one character per cycle, none from the last to that load.
// Reset: asynchronous, active low; scanner returns to skipping leading white space,
// all fields clear to zero and the result register is empty.
module http_date_to_epoch_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  hdep_char_if.sink  char_i,
  hdep_epoch_if.source epoch_o
);

  hdep_pkg::hdep_cmd_t cmd;
  hdep_pkg::hdep_sts_t sts;

  // Scanner and conversion sequencer.
  hdep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (char_i.valid),
    .char_byte_i (char_i.char_byte),
    .is_last_i   (char_i.is_last),
    .in_ready_o  (char_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Field storage and arithmetic.
  hdep_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .char_byte_i     (char_i.char_byte),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (epoch_o.valid),
    .out_ready_i     (epoch_o.ready),
    .epoch_seconds_o (epoch_o.epoch_seconds),
    .month_found_o   (epoch_o.month_found)
  );

  // Field updates happen only on an accepted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.acc_en || cmd.mon_shift || cmd.mon_match) |-> (char_i.valid && char_i.ready))
    else $error("field update without an accepted word");

  // The last character stops input until the result is built.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_i.valid && char_i.ready && char_i.is_last) |=> !char_i.ready)
    else $error("input taken during conversion");

  // A result load always shows up at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> epoch_o.valid)
    else $error("result load lost");

  // A result is never loaded over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!epoch_o.valid || epoch_o.ready))
    else $error("result overwritten");

endmodule
